// File: rtl/windowed_mean_median_smoother_unit_macros.svh
// Assertion macros used by the smoother top module.
`ifndef WINDOWED_MEAN_MEDIAN_SMOOTHER_UNIT_MACROS_SVH
`define WINDOWED_MEAN_MEDIAN_SMOOTHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smoother assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WMMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smoother assertion failed");

`endif

// File: rtl/wmms_pkg.sv
`default_nettype none
package wmms_pkg;
   localparam int TIME_W  = 48;
   localparam int VALUE_W = 32;

   localparam logic CSR_SMOOTH_MODE = 1'b0;
   localparam logic CSR_HALF_WIDTH  = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CENTER,
      OP_SCAN,
      OP_CAND,
      OP_RANK
   } op_type;

   typedef enum logic [1:0] {
      SEL_PASS,
      SEL_EMPTY,
      SEL_MEAN,
      SEL_MEDIAN
   } sel_type;

   typedef struct packed {
      logic    store_en;
      op_type  op;
      logic    clr_acc;
      logic    clr_rank;
      logic    rank_eval;
      logic    div_start;
      logic    div_step;
      logic    out_load;
      sel_type out_sel;
      logic    out_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;
endpackage
`default_nettype wire

// File: rtl/windowed_mean_median_smoother_unit.sv
`default_nettype none
// Loads up to MAX_SLOTS time-tagged samples, one transfer per cycle; further
// samples of a series are dropped. The transfer with req_tlast starts the
// output pass, which emits one result per stored slot in arrival order and
// takes no input until the last result is loaded. For each slot the n stored
// samples are walked through the single sample memory port, then the
// bit-serial mean divider runs, or, for a median over a window of m samples,
// the median is found by rank counting over the window buffer read port;
// the result is then loaded, and the load waits while the result channel
// stalls. A one-sample series passes through. Configuration must be written
// only while no series is in flight; the block itself does not enforce this.
module windowed_mean_median_smoother_unit import wmms_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,   // sample_time[47:0], sample_value[79:48]
   input  wire logic         req_tuser,   // sample_valid
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // smoothed_value[31:0]
   output logic              rsp_tuser,   // smoothed_valid
   output logic              rsp_tlast,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [47:0]  csr_wdata
);
   `include "windowed_mean_median_smoother_unit_macros.svh"

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);

   logic              smooth_mode_ff;
   logic [TIME_W-1:0] half_width_ff;
   cmd_type           cmd;
   stat_type          stat;
   logic [IW-1:0]     slot_addr, win_addr;
   logic [CW-1:0]     win_cnt;
   logic              in_transfer;
   logic signed [VALUE_W-1:0] out_value;

   assign in_transfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_mode_ff <= 1'b0;
         half_width_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTH_MODE: smooth_mode_ff <= csr_wdata[0];
            CSR_HALF_WIDTH:  half_width_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wmms_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_transfer (in_transfer),
      .in_last     (req_tlast),
      .smooth_mode (smooth_mode_ff),
      .win_cnt     (win_cnt),
      .stat        (stat),
      .in_ready    (req_tready),
      .cmd         (cmd),
      .slot_addr   (slot_addr),
      .win_addr    (win_addr)
   );

   wmms_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .slot_addr  (slot_addr),
      .win_addr   (win_addr),
      .in_time    (req_tdata[47:0]),
      .in_value   ($signed(req_tdata[79:48])),
      .in_valid   (req_tuser),
      .half_width (half_width_ff),
      .rsp_tready (rsp_tready),
      .win_cnt    (win_cnt),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .out_value  (out_value),
      .out_valid  (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = out_value;

   `WMMS_ASSERT_NEXT(a_last_stops_input, clock, reset, in_transfer && req_tlast, !req_tready)
   `WMMS_ASSERT_SAME(a_mid_result_busy, clock, reset, $rose(rsp_tvalid) && !rsp_tlast, !req_tready)
endmodule
`default_nettype wire

// File: rtl/wmms_datapath.sv
`default_nettype none
module wmms_datapath import wmms_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmd_type                           cmd,
   input  wire logic [$clog2(MAX_SLOTS)-1:0]      slot_addr,
   input  wire logic [$clog2(MAX_SLOTS)-1:0]      win_addr,
   input  wire logic [TIME_W-1:0]                 in_time,
   input  wire logic signed [VALUE_W-1:0]         in_value,
   input  wire logic                              in_valid,
   input  wire logic [TIME_W-1:0]                 half_width,
   input  wire logic                              rsp_tready,
   output logic [$clog2(MAX_SLOTS+1)-1:0]         win_cnt,
   output stat_type                               stat,
   output logic                                   rsp_tvalid,
   output logic signed [VALUE_W-1:0]              out_value,
   output logic                                   out_valid,
   output logic                                   out_last
);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int SW = VALUE_W + CW;

   logic [TIME_W-1:0]         time_mem  [MAX_SLOTS];
   logic signed [VALUE_W-1:0] value_mem [MAX_SLOTS];
   logic                      valid_mem [MAX_SLOTS];
   logic signed [VALUE_W-1:0] win_mem   [MAX_SLOTS];

   logic [TIME_W-1:0]         rd_time_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;
   logic                      rd_valid_ff;
   logic signed [VALUE_W-1:0] win_rd_ff;
   op_type                    op_ff;

   logic signed [VALUE_W-1:0] ctr_value_ff;
   logic                      ctr_valid_ff;
   logic [TIME_W:0]           hi_ff;
   logic signed [TIME_W+1:0]  lo_ff;
   logic signed [SW-1:0]      sum_ff;
   logic [CW-1:0]             cnt_ff;

   logic signed [VALUE_W-1:0] cand_ff, v1_ff, v2_ff;
   logic [CW-1:0]             less_ff, eq_ff;

   logic [SW-1:0]             dq_ff;
   logic [CW:0]               rem_ff;
   logic                      neg_ff;

   logic                      rsp_tvalid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_valid_ff, out_last_ff;

   logic                      in_win;
   logic [CW:0]               rem_sh, rem_in;
   logic                      rem_ge;
   logic [CW-1:0]             k1, k2;
   logic [CW:0]               less_eq;
   logic signed [VALUE_W:0]   msum, mrnd;
   logic signed [VALUE_W-1:0] med, mean;

   always_comb begin
      in_win = rd_valid_ff && ({1'b0, rd_time_ff} <= hi_ff) &&
               ($signed({2'b00, rd_time_ff}) > lo_ff);
      rem_sh = {rem_ff[CW-1:0], dq_ff[SW-1]};
      rem_ge = rem_sh >= {1'b0, cnt_ff};
      rem_in = rem_ge ? rem_sh - {1'b0, cnt_ff} : rem_sh;
      k1 = (cnt_ff - 1'b1) >> 1;
      k2 = cnt_ff >> 1;
      less_eq = {1'b0, less_ff} + {1'b0, eq_ff};
      msum = {v1_ff[VALUE_W-1], v1_ff} + {v2_ff[VALUE_W-1], v2_ff};
      mrnd = msum + (VALUE_W+1)'(msum[VALUE_W]);
      med  = cnt_ff[0] ? v1_ff : mrnd[VALUE_W:1];
      mean = neg_ff ? -$signed(dq_ff[VALUE_W-1:0]) : $signed(dq_ff[VALUE_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         time_mem[slot_addr]  <= in_time;
         value_mem[slot_addr] <= in_value;
         valid_mem[slot_addr] <= in_valid;
      end
      rd_time_ff  <= time_mem[slot_addr];
      rd_value_ff <= value_mem[slot_addr];
      rd_valid_ff <= valid_mem[slot_addr];
      win_rd_ff   <= win_mem[win_addr];
      if (op_ff == OP_SCAN && in_win) begin
         win_mem[cnt_ff[IW-1:0]] <= rd_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff         <= OP_NONE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         op_ff <= cmd.op;
         if (cmd.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_ff == OP_CENTER) begin
         ctr_value_ff <= rd_value_ff;
         ctr_valid_ff <= rd_valid_ff;
         hi_ff <= {1'b0, rd_time_ff} + {1'b0, half_width};
         lo_ff <= $signed({2'b00, rd_time_ff}) - $signed({2'b00, half_width});
      end
      if (cmd.clr_acc) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (op_ff == OP_SCAN && in_win) begin
         sum_ff <= sum_ff + SW'(rd_value_ff);
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (op_ff == OP_CAND) begin
         cand_ff <= win_rd_ff;
      end
      if (cmd.clr_rank) begin
         less_ff <= '0;
         eq_ff   <= '0;
      end else if (op_ff == OP_RANK) begin
         if (win_rd_ff < cand_ff) begin
            less_ff <= less_ff + 1'b1;
         end
         if (win_rd_ff == cand_ff) begin
            eq_ff <= eq_ff + 1'b1;
         end
      end
      if (cmd.rank_eval) begin
         if (less_ff <= k1 && {1'b0, k1} < less_eq) begin
            v1_ff <= cand_ff;
         end
         if (less_ff <= k2 && {1'b0, k2} < less_eq) begin
            v2_ff <= cand_ff;
         end
      end
      if (cmd.div_start) begin
         neg_ff <= sum_ff[SW-1];
         dq_ff  <= sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[SW-2:0], rem_ge};
      end
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_last;
         case (cmd.out_sel)
            SEL_PASS: begin
               out_value_ff <= ctr_value_ff;
               out_valid_ff <= ctr_valid_ff;
            end
            SEL_EMPTY: begin
               out_value_ff <= ctr_value_ff;
               out_valid_ff <= 1'b0;
            end
            SEL_MEAN: begin
               out_value_ff <= mean;
               out_valid_ff <= 1'b1;
            end
            default: begin
               out_value_ff <= med;
               out_valid_ff <= 1'b1;
            end
         endcase
      end
   end

   assign win_cnt         = cnt_ff;
   assign stat.out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign out_value       = out_value_ff;
   assign out_valid       = out_valid_ff;
   assign out_last        = out_last_ff;
endmodule
`default_nettype wire

// File: rtl/wmms_ctrl.sv
`default_nettype none
module wmms_ctrl import wmms_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_transfer,
   input  wire logic                              in_last,
   input  wire logic                              smooth_mode,
   input  wire logic [$clog2(MAX_SLOTS+1)-1:0]    win_cnt,
   input  wire stat_type                          stat,
   output logic                                   in_ready,
   output cmd_type                                cmd,
   output logic [$clog2(MAX_SLOTS)-1:0]           slot_addr,
   output logic [$clog2(MAX_SLOTS)-1:0]           win_addr
);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int SW = VALUE_W + CW;
   localparam int DW = $clog2(SW);

   typedef enum logic [3:0] {
      S_LOAD, S_CENTER, S_CENTER_W, S_SCAN, S_SCAN_W, S_DECIDE, S_DIV,
      S_CAND, S_CAND_W, S_RANK, S_RANK_W, S_EVAL, S_OUT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] idx_ff, scan_ff, cidx_ff;
   logic [DW-1:0] div_ff;
   sel_type       sel_ff;

   logic          idx_last, scan_n_last, scan_w_last, cidx_last;

   always_comb begin
      idx_last    = CW'(idx_ff) == count_ff - 1'b1;
      scan_n_last = CW'(scan_ff) == count_ff - 1'b1;
      scan_w_last = CW'(scan_ff) == win_cnt - 1'b1;
      cidx_last   = CW'(cidx_ff) == win_cnt - 1'b1;
   end

   always_comb begin
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.out_sel = sel_ff;
      cmd.out_last = idx_last;
      in_ready  = state_ff == S_LOAD;
      slot_addr = idx_ff;
      win_addr  = scan_ff;
      case (state_ff)
         S_LOAD: begin
            slot_addr    = count_ff[IW-1:0];
            cmd.store_en = in_transfer && (count_ff < CW'(MAX_SLOTS));
         end
         S_CENTER: begin
            cmd.op      = OP_CENTER;
            cmd.clr_acc = 1'b1;
         end
         S_SCAN: begin
            slot_addr = scan_ff;
            cmd.op    = OP_SCAN;
         end
         S_DECIDE: begin
            cmd.div_start = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_CAND: begin
            win_addr     = cidx_ff;
            cmd.op       = OP_CAND;
            cmd.clr_rank = 1'b1;
         end
         S_RANK: begin
            cmd.op = OP_RANK;
         end
         S_EVAL: begin
            cmd.rank_eval = 1'b1;
         end
         S_OUT: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         idx_ff   <= '0;
         scan_ff  <= '0;
         cidx_ff  <= '0;
         div_ff   <= '0;
         sel_ff   <= SEL_PASS;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (in_transfer) begin
                  if (count_ff < CW'(MAX_SLOTS)) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (in_last) begin
                     idx_ff   <= '0;
                     state_ff <= S_CENTER;
                  end
               end
            end
            S_CENTER: begin
               state_ff <= S_CENTER_W;
            end
            S_CENTER_W: begin
               scan_ff <= '0;
               if (count_ff == CW'(1)) begin
                  sel_ff   <= SEL_PASS;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_n_last) begin
                  state_ff <= S_SCAN_W;
               end
            end
            S_SCAN_W: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               div_ff  <= '0;
               cidx_ff <= '0;
               if (win_cnt == '0) begin
                  sel_ff   <= SEL_EMPTY;
                  state_ff <= S_OUT;
               end else if (!smooth_mode) begin
                  sel_ff   <= SEL_MEAN;
                  state_ff <= S_DIV;
               end else begin
                  sel_ff   <= SEL_MEDIAN;
                  state_ff <= S_CAND;
               end
            end
            S_DIV: begin
               div_ff <= div_ff + 1'b1;
               if (div_ff == DW'(SW - 1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_CAND: begin
               state_ff <= S_CAND_W;
            end
            S_CAND_W: begin
               scan_ff  <= '0;
               state_ff <= S_RANK;
            end
            S_RANK: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_w_last) begin
                  state_ff <= S_RANK_W;
               end
            end
            S_RANK_W: begin
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               cidx_ff <= cidx_ff + 1'b1;
               state_ff <= cidx_last ? S_OUT : S_CAND;
            end
            S_OUT: begin
               if (stat.out_free) begin
                  if (idx_last) begin
                     count_ff <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_CENTER;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end
endmodule
`default_nettype wire
